// ===== sv/piezo_stick_slip_stepper_macros.svh =====
// Assertion macros for the piezo stick-slip stepper.
// Included by the RTL files that carry concurrent checks; depends on clk and rst_n.
`ifndef PIEZO_STICK_SLIP_STEPPER_MACROS_SVH
`define PIEZO_STICK_SLIP_STEPPER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define PSS_CHECK(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled during reset.
`define PSS_CHECK_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== sv/pss_pkg.sv =====
// Types and constants for the piezo stick-slip stepper.
// Used by piezo_stick_slip_stepper; depends on nothing else.
`timescale 1ns / 1ps

package pss_pkg;

    typedef enum logic [2:0] {
        CS_IDLE    = 3'd0,
        CS_RETRACT = 3'd1,
        CS_STEP    = 3'd2,
        CS_MEASURE = 3'd3,
        CS_FINISH  = 3'd4
    } ctl_state_t;

    typedef enum logic [2:0] {
        SQ_IDLE,
        SQ_PREP,
        SQ_EVAL,
        SQ_MOD,
        SQ_MUL,
        SQ_DIV,
        SQ_DONE
    } seq_state_t;

    typedef enum logic [2:0] {
        RG_MODE   = 3'd0,
        RG_STEPS  = 3'd1,
        RG_THRESH = 3'd2,
        RG_TPW    = 3'd3,
        RG_RSTEP  = 3'd4
    } reg_idx_t;

    localparam logic [1:0] MODE_DOWN = 2'd1;

    localparam int DIV_W     = 35;
    localparam int DIV_CNT_W = 6;
    localparam int MAG_W     = 19;

    localparam logic signed [20:0] UP_TARGET_MV   = 21'sd80000;
    localparam logic signed [20:0] DOWN_TARGET_MV = -21'sd270000;
    localparam logic signed [20:0] UP_BASE_MV     = -21'sd270000;
    localparam logic signed [20:0] DOWN_BASE_MV   = -21'sd80000;
    localparam logic [MAG_W-1:0]   UP_SPAN_MV     = 19'd350000;
    localparam logic [MAG_W-1:0]   DOWN_SPAN_MV   = 19'd190000;

    localparam logic [15:0] TPW_MIN = 16'd2;

endpackage

// ===== sv/piezo_stick_slip_stepper.sv =====
// Stick-slip stepper controller for a Z piezo, one beat per control-loop tick.
// Uses pss_pkg and piezo_stick_slip_stepper_macros.svh.
//
//   channel | signals                                   | beat
//   input   | in_valid, in_stall, tick fields           | one control-loop tick
//   output  | out_valid, out_stall, result fields       | one result per tick
//   config  | psel, penable, pwrite, paddr, pwdata, ... | one register write
//
// A stepping tick uses one shared 35-step restoring divider, which forms the wave
// phase and then the scaled wave amplitude. One tick is in work at a time.
// Reset clears the state and loads the config defaults at once; no clearing pass.
// A new tick is accepted while a result waits on a stalled output; a finished tick
// then waits until that result has been taken.
`timescale 1ns / 1ps
`include "piezo_stick_slip_stepper_macros.svh"

module piezo_stick_slip_stepper
    import pss_pkg::*;
#(
    parameter int TICK_COUNT_WIDTH = 32
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic               start_req,
    input  logic               tracker_done,
    input  logic [19:0]        capacitance,
    input  logic signed [19:0] z_voltage_now,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [2:0]         control_state,
    output logic               drive_z,
    output logic signed [19:0] z_voltage,
    output logic               bias_zero,
    output logic               restart_tracker,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int W = TICK_COUNT_WIDTH;

    logic [1:0]  mode_reg;
    logic [15:0] steps_reg;
    logic [15:0] thresh_reg;
    logic [15:0] tpw_reg;
    logic [16:0] rstep_reg;

    seq_state_t seq_reg, seq_next;
    ctl_state_t ctl_state_reg, ctl_state_next;
    logic       retract_done_reg, retract_done_next;
    logic [W-1:0] elapsed_reg, elapsed_next;
    logic [15:0]  wave_phase_reg, wave_phase_next;

    logic               start_req_reg, start_req_next;
    logic               tracker_done_reg, tracker_done_next;
    logic [19:0]        capacitance_reg, capacitance_next;
    logic signed [19:0] z_now_reg, z_now_next;
    logic [31:0]        seq_prod_reg, seq_prod_next;

    ctl_state_t         res_state_reg, res_state_next;
    logic               res_drive_reg, res_drive_next;
    logic signed [19:0] res_volt_reg, res_volt_next;
    logic               res_bias_reg, res_bias_next;
    logic               res_restart_reg, res_restart_next;
    logic               wave_reg, wave_next;

    logic [DIV_W-1:0]     quo_reg, quo_next;
    logic [15:0]          rem_reg, rem_next;
    logic [15:0]          den_reg, den_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;

    logic               out_valid_reg, out_valid_next;
    ctl_state_t         out_state_reg, out_state_next;
    logic               out_drive_reg, out_drive_next;
    logic signed [19:0] out_volt_reg, out_volt_next;
    logic               out_bias_reg, out_bias_next;
    logic               out_restart_reg, out_restart_next;

    logic        in_accept;
    logic        out_free;
    logic        cfg_write;
    logic        capmode;
    logic        down;
    logic [15:0] tpw_eff;
    logic [14:0] half;

    ctl_state_t         ev_state;
    logic               ev_rd;
    logic [W-1:0]       ev_el;
    logic               ev_restart;
    logic               ev_drive;
    logic               ev_bias;
    logic               ev_step;
    logic signed [19:0] ev_volt;
    logic signed [20:0] rt_target;
    logic signed [20:0] rt_now;
    logic signed [20:0] rt_diff;

    logic [16:0]        div_shift;
    logic               div_ge;
    logic [16:0]        div_sub;
    logic [15:0]        div_rem;
    logic [DIV_W-1:0]   div_quo;
    logic [15:0]        phase_ofs;
    logic [DIV_W-1:0]   num;
    logic signed [20:0] wave_volt;

    assign in_accept = in_valid && !in_stall;
    assign out_free  = !out_valid_reg || !out_stall;
    assign cfg_write = psel && penable && pwrite && pready;
    assign capmode   = mode_reg[1];
    assign down      = (mode_reg == MODE_DOWN);
    assign tpw_eff   = (tpw_reg < TPW_MIN) ? TPW_MIN : tpw_reg;
    assign half      = tpw_eff[15:1];

    always_comb
    begin
        unique case (reg_idx_t'(paddr[4:2]))
            RG_MODE:   prdata = 32'(mode_reg);
            RG_STEPS:  prdata = 32'(steps_reg);
            RG_THRESH: prdata = 32'(thresh_reg);
            RG_TPW:    prdata = 32'(tpw_reg);
            RG_RSTEP:  prdata = 32'(rstep_reg);
            default:   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= 2'd0;
            steps_reg  <= 16'd1;
            thresh_reg <= 16'd0;
            tpw_reg    <= 16'd100;
            rstep_reg  <= 17'd1400;
        end
        else if (cfg_write)
        begin
            unique case (reg_idx_t'(paddr[4:2]))
                RG_MODE:   mode_reg   <= pwdata[1:0];
                RG_STEPS:  steps_reg  <= pwdata[15:0];
                RG_THRESH: thresh_reg <= pwdata[15:0];
                RG_TPW:    tpw_reg    <= pwdata[15:0];
                RG_RSTEP:  rstep_reg  <= pwdata[16:0];
                default:   ;
            endcase
        end
    end

    // Control decisions of one tick, in the order start, retract end, burst end,
    // measurement result, drive.
    always_comb
    begin
        ev_state   = ctl_state_reg;
        ev_rd      = retract_done_reg;
        ev_el      = elapsed_reg;
        ev_restart = 1'b0;
        ev_drive   = 1'b0;
        ev_bias    = 1'b0;
        ev_step    = 1'b0;
        ev_volt    = 20'sd0;
        rt_target  = down ? DOWN_TARGET_MV : UP_TARGET_MV;
        rt_now     = 21'(z_now_reg);
        rt_diff    = rt_now - $signed({4'b0000, rstep_reg});
        if (start_req_reg)
        begin
            ev_rd = 1'b0;
            ev_el = '0;
            if (capmode)
            begin
                ev_state   = CS_MEASURE;
                ev_restart = 1'b1;
            end
            else
            begin
                ev_state = CS_RETRACT;
            end
        end
        if (ev_state == CS_RETRACT && ev_rd)
        begin
            ev_state = CS_STEP;
            ev_el    = '0;
        end
        if (ev_state == CS_STEP)
        begin
            if (32'(ev_el) >= seq_prod_reg || (&ev_el))
            begin
                if (capmode)
                begin
                    ev_state   = CS_MEASURE;
                    ev_restart = 1'b1;
                end
                else
                begin
                    ev_state = CS_FINISH;
                end
            end
        end
        if (ev_state == CS_MEASURE && !ev_restart && tracker_done_reg)
        begin
            ev_state = (capacitance_reg > 20'(thresh_reg)) ? CS_FINISH : CS_STEP;
            ev_el    = '0;
        end
        if (ev_state == CS_RETRACT || ev_state == CS_STEP || ev_state == CS_FINISH)
        begin
            ev_bias = 1'b1;
        end
        if (ev_state == CS_RETRACT)
        begin
            ev_drive = 1'b1;
            if (rt_now > rt_target)
            begin
                ev_volt = (rt_diff < rt_target) ? 20'(rt_target) : 20'(rt_diff);
            end
            else
            begin
                ev_rd   = 1'b1;
                ev_volt = z_now_reg;
            end
        end
        if (ev_state == CS_STEP)
        begin
            ev_drive = 1'b1;
            ev_step  = 1'b1;
        end
    end

    // Shared restoring divider step and wave arithmetic.
    always_comb
    begin
        div_shift = {rem_reg, quo_reg[DIV_W-1]};
        div_ge    = (div_shift >= {1'b0, den_reg});
        div_sub   = div_shift - {1'b0, den_reg};
        div_rem   = div_ge ? div_sub[15:0] : div_shift[15:0];
        div_quo   = {quo_reg[DIV_W-2:0], div_ge};
        phase_ofs = rem_reg - {1'b0, half};
        if (down)
        begin
            num = (rem_reg >= {1'b0, half}) ?
                  DIV_W'(phase_ofs) * DIV_W'(DOWN_SPAN_MV) : '0;
            wave_volt = DOWN_BASE_MV - $signed({2'b00, quo_reg[MAG_W-1:0]});
        end
        else
        begin
            num = (rem_reg <= {1'b0, half}) ?
                  DIV_W'(rem_reg) * DIV_W'(UP_SPAN_MV) : '0;
            wave_volt = UP_BASE_MV + $signed({2'b00, quo_reg[MAG_W-1:0]});
        end
    end

    always_comb
    begin
        seq_next = seq_reg;
        unique case (seq_reg)
            SQ_IDLE: if (in_accept) seq_next = SQ_PREP;
            SQ_PREP: seq_next = SQ_EVAL;
            SQ_EVAL: seq_next = ev_step ? SQ_MOD : SQ_DONE;
            SQ_MOD:  if (cnt_reg == '0) seq_next = SQ_MUL;
            SQ_MUL:  seq_next = SQ_DIV;
            SQ_DIV:  if (cnt_reg == '0) seq_next = SQ_DONE;
            SQ_DONE: if (out_free) seq_next = SQ_IDLE;
            default: seq_next = SQ_IDLE;
        endcase
    end

    always_comb
    begin
        in_stall        = (seq_reg != SQ_IDLE);
        out_valid       = out_valid_reg;
        control_state   = out_state_reg;
        drive_z         = out_drive_reg;
        z_voltage       = out_volt_reg;
        bias_zero       = out_bias_reg;
        restart_tracker = out_restart_reg;
        pready          = 1'b1;
    end

    always_comb
    begin
        ctl_state_next    = ctl_state_reg;
        retract_done_next = retract_done_reg;
        elapsed_next      = elapsed_reg;
        wave_phase_next   = wave_phase_reg;
        start_req_next    = start_req_reg;
        tracker_done_next = tracker_done_reg;
        capacitance_next  = capacitance_reg;
        z_now_next        = z_now_reg;
        seq_prod_next     = seq_prod_reg;
        res_state_next    = res_state_reg;
        res_drive_next    = res_drive_reg;
        res_volt_next     = res_volt_reg;
        res_bias_next     = res_bias_reg;
        res_restart_next  = res_restart_reg;
        wave_next         = wave_reg;
        quo_next          = quo_reg;
        rem_next          = rem_reg;
        den_next          = den_reg;
        cnt_next          = cnt_reg;
        out_valid_next    = out_valid_reg && out_stall;
        out_state_next    = out_state_reg;
        out_drive_next    = out_drive_reg;
        out_volt_next     = out_volt_reg;
        out_bias_next     = out_bias_reg;
        out_restart_next  = out_restart_reg;
        unique case (seq_reg)
            SQ_IDLE:
            begin
                if (in_accept)
                begin
                    start_req_next    = start_req;
                    tracker_done_next = tracker_done;
                    capacitance_next  = capacitance;
                    z_now_next        = z_voltage_now;
                end
            end
            SQ_PREP:
            begin
                seq_prod_next = 32'(tpw_eff) * 32'(steps_reg);
            end
            SQ_EVAL:
            begin
                ctl_state_next    = ev_state;
                retract_done_next = ev_rd;
                elapsed_next      = (ev_step && !(&ev_el)) ? ev_el + 1'b1 : ev_el;
                res_state_next    = ev_state;
                res_drive_next    = ev_drive;
                res_volt_next     = ev_volt;
                res_bias_next     = ev_bias;
                res_restart_next  = ev_restart;
                wave_next         = ev_step;
                quo_next          = DIV_W'(ev_el);
                rem_next          = 16'd0;
                den_next          = tpw_eff;
                cnt_next          = DIV_CNT_W'(DIV_W - 1);
            end
            SQ_MOD, SQ_DIV:
            begin
                quo_next = div_quo;
                rem_next = div_rem;
                if (cnt_reg != '0)
                begin
                    cnt_next = cnt_reg - 1'b1;
                end
            end
            SQ_MUL:
            begin
                wave_phase_next = rem_reg;
                quo_next        = num;
                rem_next        = 16'd0;
                den_next        = {1'b0, half};
                cnt_next        = DIV_CNT_W'(DIV_W - 1);
            end
            SQ_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next   = 1'b1;
                    out_state_next   = res_state_reg;
                    out_drive_next   = res_drive_reg;
                    out_volt_next    = wave_reg ? 20'(wave_volt) : res_volt_reg;
                    out_bias_next    = res_bias_reg;
                    out_restart_next = res_restart_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg          <= SQ_IDLE;
            ctl_state_reg    <= CS_IDLE;
            retract_done_reg <= 1'b0;
            elapsed_reg      <= '0;
            wave_phase_reg   <= 16'd0;
            cnt_reg          <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            seq_reg          <= seq_next;
            ctl_state_reg    <= ctl_state_next;
            retract_done_reg <= retract_done_next;
            elapsed_reg      <= elapsed_next;
            wave_phase_reg   <= wave_phase_next;
            cnt_reg          <= cnt_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        start_req_reg    <= start_req_next;
        tracker_done_reg <= tracker_done_next;
        capacitance_reg  <= capacitance_next;
        z_now_reg        <= z_now_next;
        seq_prod_reg     <= seq_prod_next;
        res_state_reg    <= res_state_next;
        res_drive_reg    <= res_drive_next;
        res_volt_reg     <= res_volt_next;
        res_bias_reg     <= res_bias_next;
        res_restart_reg  <= res_restart_next;
        wave_reg         <= wave_next;
        quo_reg          <= quo_next;
        rem_reg          <= rem_next;
        den_reg          <= den_next;
        out_state_reg    <= out_state_next;
        out_drive_reg    <= out_drive_next;
        out_volt_reg     <= out_volt_next;
        out_bias_reg     <= out_bias_next;
        out_restart_reg  <= out_restart_next;
    end

    `PSS_CHECK(a_idle_drive_zero, out_valid && !drive_z, z_voltage == 20'sd0,
        "Undriven result carries a nonzero voltage.")
    `PSS_CHECK(a_bias_state, out_valid,
        bias_zero == (control_state == CS_RETRACT || control_state == CS_STEP ||
                      control_state == CS_FINISH),
        "Bias strobe disagrees with the control state.")
    `PSS_CHECK(a_restart_measure, out_valid && restart_tracker,
        control_state == CS_MEASURE, "Tracker restart outside measuring.")
    `PSS_CHECK(a_div_rem_bound, seq_reg == SQ_MOD || seq_reg == SQ_DIV,
        rem_reg < den_reg, "Divider remainder reached the divisor.")
    `PSS_CHECK_NEXT(a_done_loads, seq_reg == SQ_DONE && out_free,
        out_valid_reg && seq_reg == SQ_IDLE, "Finished tick did not reach the output.")

endmodule
